@@ rtl/core/wav_chunk_parser_top_defines.svh @@
// Assertion macros shared by the WAVE chunk parser RTL.
`ifndef WAV_CHUNK_PARSER_TOP_DEFINES_SVH
`define WAV_CHUNK_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WCP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define WCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/wcp_pkg.sv @@
// Types and constants for the WAVE chunk parser.
`default_nettype none
package wcp_pkg;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_FORM,
    PH_FMT,
    PH_SKIP,
    PH_DATA
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE     = 2'd0,
    KIND_REPORT     = 2'd1,
    KIND_BAD_FORMAT = 2'd2,
    KIND_NO_DATA    = 2'd3
  } kind_t;

  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_BYTES = 32'd16;
  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [12:0] BPS_ONE   = 13'd1;
  localparam logic [12:0] BPS_TWO   = 13'd2;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int unsigned TDATA_W = 192;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] sample_value;
    logic [15:0]        channel;
    logic               frame_end;
    logic [15:0]        fmt_code;
    logic [15:0]        chan_total;
    logic [31:0]        samp_rate;
    logic [31:0]        data_rate;
    logic [15:0]        frame_bytes;
    logic [15:0]        samp_bits;
    logic [31:0]        form_type;
  } wcp_result_t;

  typedef struct packed {
    logic                full;
    logic                empty;
    logic [QUEUE_AW:0]   count;
  } wcp_qstat_t;

endpackage
`default_nettype wire

@@ rtl/core/wav_chunk_parser_top.sv @@
// Top level of the RIFF/WAVE PCM chunk parser.
// Input stream: one file octet per transfer on in_tdata; in_tlast marks end of
// file and its octet is ignored. Output stream: one result per transfer, with
// the kind on out_tuser (sample, format report, unsupported format, no data
// chunk) and end of frame on out_tlast for samples.
// An octet is taken every cycle while in_tready is high; a result is written
// into the queue at the edge that accepts its octet, then moves to the output
// register behind out_tvalid; results drain at one per cycle while out_tready
// is high. Sustained rate is one octet per cycle while the queue has room.
// A four-entry queue sits between the parser and the output register; when the
// receiver stalls the queue fills and in_tready drops until a slot frees.
// Reset clears the parser to header collection with all captured fields zero
// and empties the queue. After an error or end of file the parser ignores all
// further octets until reset; the pending results still drain.
`default_nettype none
`include "wav_chunk_parser_top_defines.svh"
module wav_chunk_parser_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,   // data_octet
  input  wire logic                        in_tlast,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // sample_value, channel, fmt_code, chan_total, samp_rate, data_rate,
  // frame_bytes, samp_bits, form_type
  output logic [wcp_pkg::TDATA_W-1:0]      out_tdata,
  output logic [1:0]                       out_tuser,  // kind
  output logic                             out_tlast
);

  logic                 q_push;
  logic                 q_pop;
  logic                 q_stop;
  wcp_pkg::wcp_result_t q_rec;
  wcp_pkg::wcp_result_t q_head;
  wcp_pkg::wcp_qstat_t  q_stat;

  wcp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (q_push),
    .push_rec  (q_rec)
  );

  wcp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (q_rec),
    .pop      (q_pop),
    .head_rec (q_head),
    .stat     (q_stat)
  );

  wcp_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head_rec   (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  assign q_stop = q_push && (q_rec.kind == wcp_pkg::KIND_BAD_FORMAT ||
                             q_rec.kind == wcp_pkg::KIND_NO_DATA);

  `WCP_ASSERT_IMPLIES(a_no_overflow, q_stat.full, !q_push, "result queue overflow")
  `WCP_ASSERT_NEXT(a_halt_quiet, q_stop, !q_push, "result after halt")
  `WCP_ASSERT_NEXT(a_count_hold, !q_push && !q_pop, $stable(q_stat.count), "queue count moved while idle")
  `WCP_ASSERT_IMPLIES(a_tlast_sample, out_tvalid && out_tlast, out_tuser == wcp_pkg::KIND_SAMPLE, "frame end on a report")

endmodule
`default_nettype wire

@@ rtl/core/wcp_front.sv @@
// Front end: accepts octets, parses RIFF/WAVE chunks and builds result records.
`default_nettype none
module wcp_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,
  input  wire logic               in_tlast,
  input  wire wcp_pkg::wcp_qstat_t q_stat,
  output logic                    push,
  output wcp_pkg::wcp_result_t    push_rec
);

  wcp_pkg::phase_t phase_r, phase_nxt;
  logic        halted_r, halted_nxt;
  logic [31:0] header_id_r, header_id_nxt;
  logic [31:0] chunk_len_r, chunk_len_nxt;
  logic [31:0] byte_count_r, byte_count_nxt;
  logic [15:0] audio_r, audio_nxt;
  logic [15:0] nch_r, nch_nxt;
  logic [15:0] align_r, align_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] brate_r, brate_nxt;
  logic [31:0] form_r, form_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [15:0] chan_r, chan_nxt;

  logic        acc;
  logic [31:0] bc_inc;
  logic [31:0] fmt_total;
  logic        emit;
  wcp_pkg::kind_t emit_kind;
  logic        smp_emit;
  logic [15:0] smp_val;
  logic        smp_last;
  logic [16:0] chan_inc;

  assign in_tready = !q_stat.full;
  assign acc       = in_tvalid && in_tready;
  assign bc_inc    = byte_count_r + 32'd1;
  assign fmt_total = (chunk_len_r > wcp_pkg::FMT_BYTES) ? chunk_len_r : wcp_pkg::FMT_BYTES;
  assign chan_inc  = {1'b0, chan_r} + 17'd1;
  assign smp_last  = chan_inc >= {1'b0, nch_r};

  always_comb begin
    phase_nxt      = phase_r;
    halted_nxt     = halted_r;
    header_id_nxt  = header_id_r;
    chunk_len_nxt  = chunk_len_r;
    byte_count_nxt = byte_count_r;
    audio_nxt      = audio_r;
    nch_nxt        = nch_r;
    align_nxt      = align_r;
    bits_nxt       = bits_r;
    rate_nxt       = rate_r;
    brate_nxt      = brate_r;
    form_nxt       = form_r;
    low_nxt        = low_r;
    chan_nxt       = chan_r;
    emit           = 1'b0;
    emit_kind      = wcp_pkg::KIND_SAMPLE;
    smp_emit       = 1'b0;
    smp_val        = 16'd0;

    if (acc && !halted_r) begin
      if (in_tlast) begin
        halted_nxt = 1'b1;
        if (phase_r != wcp_pkg::PH_DATA) begin
          emit      = 1'b1;
          emit_kind = wcp_pkg::KIND_NO_DATA;
        end
      end else begin
        case (phase_r)
          wcp_pkg::PH_FORM: begin
            form_nxt[byte_count_r[1:0]*8 +: 8] = in_tdata;
            byte_count_nxt = bc_inc;
            if (byte_count_r[1:0] == 2'd3) begin
              phase_nxt      = wcp_pkg::PH_HDR;
              byte_count_nxt = 32'd0;
            end
          end
          wcp_pkg::PH_FMT: begin
            if (byte_count_r[31:4] == 28'd0) begin
              case (byte_count_r[3:0]) inside
                [4'd0:4'd1]:   audio_nxt[byte_count_r[0]*8 +: 8] = in_tdata;
                [4'd2:4'd3]:   nch_nxt[byte_count_r[0]*8 +: 8] = in_tdata;
                [4'd4:4'd7]:   rate_nxt[byte_count_r[1:0]*8 +: 8] = in_tdata;
                [4'd8:4'd11]:  brate_nxt[byte_count_r[1:0]*8 +: 8] = in_tdata;
                [4'd12:4'd13]: align_nxt[byte_count_r[0]*8 +: 8] = in_tdata;
                default:       bits_nxt[byte_count_r[0]*8 +: 8] = in_tdata;
              endcase
            end
            byte_count_nxt = bc_inc;
            if (byte_count_r == wcp_pkg::FMT_BYTES - 32'd1 && audio_nxt != wcp_pkg::FMT_PCM) begin
              halted_nxt = 1'b1;
              emit       = 1'b1;
              emit_kind  = wcp_pkg::KIND_BAD_FORMAT;
            end else if (bc_inc == fmt_total) begin
              phase_nxt      = wcp_pkg::PH_HDR;
              byte_count_nxt = 32'd0;
            end
          end
          wcp_pkg::PH_SKIP: begin
            byte_count_nxt = bc_inc;
            if (bc_inc == chunk_len_r) begin
              phase_nxt      = wcp_pkg::PH_HDR;
              byte_count_nxt = 32'd0;
            end
          end
          wcp_pkg::PH_DATA: begin
            if (nch_r != 16'd0) begin
              if (bits_r[15:3] == wcp_pkg::BPS_ONE) begin
                smp_emit = 1'b1;
                smp_val  = {8'd0, in_tdata};
              end else if (bits_r[15:3] == wcp_pkg::BPS_TWO) begin
                if (!byte_count_r[0]) begin
                  low_nxt        = in_tdata;
                  byte_count_nxt = 32'd1;
                end else begin
                  byte_count_nxt = 32'd0;
                  smp_emit       = 1'b1;
                  smp_val        = {in_tdata, low_r};
                end
              end
            end
          end
          default: begin
            phase_nxt = wcp_pkg::PH_HDR;
            if (!byte_count_r[2]) begin
              header_id_nxt[byte_count_r[1:0]*8 +: 8] = in_tdata;
            end else begin
              chunk_len_nxt[byte_count_r[1:0]*8 +: 8] = in_tdata;
            end
            byte_count_nxt = bc_inc;
            if (byte_count_r[2:0] == 3'd7) begin
              byte_count_nxt = 32'd0;
              if (header_id_r == wcp_pkg::ID_RIFF) begin
                phase_nxt = wcp_pkg::PH_FORM;
                form_nxt  = 32'd0;
              end else if (header_id_r == wcp_pkg::ID_FMT) begin
                phase_nxt = wcp_pkg::PH_FMT;
              end else if (header_id_r == wcp_pkg::ID_DATA) begin
                phase_nxt = wcp_pkg::PH_DATA;
                chan_nxt  = 16'd0;
                low_nxt   = 8'd0;
                emit      = 1'b1;
                emit_kind = wcp_pkg::KIND_REPORT;
              end else if (chunk_len_nxt != 32'd0) begin
                phase_nxt = wcp_pkg::PH_SKIP;
              end
            end
          end
        endcase
      end
    end

    if (smp_emit) begin
      chan_nxt = smp_last ? 16'd0 : chan_inc[15:0];
    end

    push     = emit || smp_emit;
    push_rec = '0;
    if (smp_emit) begin
      push_rec.kind         = wcp_pkg::KIND_SAMPLE;
      push_rec.sample_value = smp_val;
      push_rec.channel      = chan_r;
      push_rec.frame_end    = smp_last;
    end else begin
      push_rec.kind        = emit_kind;
      push_rec.fmt_code    = audio_nxt;
      push_rec.chan_total  = nch_nxt;
      push_rec.samp_rate   = rate_nxt;
      push_rec.data_rate   = brate_nxt;
      push_rec.frame_bytes = align_nxt;
      push_rec.samp_bits   = bits_nxt;
      push_rec.form_type   = form_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= wcp_pkg::PH_HDR;
      halted_r     <= 1'b0;
      header_id_r  <= 32'd0;
      chunk_len_r  <= 32'd0;
      byte_count_r <= 32'd0;
      audio_r      <= 16'd0;
      nch_r        <= 16'd0;
      align_r      <= 16'd0;
      bits_r       <= 16'd0;
      rate_r       <= 32'd0;
      brate_r      <= 32'd0;
      form_r       <= 32'd0;
      low_r        <= 8'd0;
      chan_r       <= 16'd0;
    end else begin
      phase_r      <= phase_nxt;
      halted_r     <= halted_nxt;
      header_id_r  <= header_id_nxt;
      chunk_len_r  <= chunk_len_nxt;
      byte_count_r <= byte_count_nxt;
      audio_r      <= audio_nxt;
      nch_r        <= nch_nxt;
      align_r      <= align_nxt;
      bits_r       <= bits_nxt;
      rate_r       <= rate_nxt;
      brate_r      <= brate_nxt;
      form_r       <= form_nxt;
      low_r        <= low_nxt;
      chan_r       <= chan_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/wcp_queue.sv @@
// Short result queue between the parser front end and the output stage.
`default_nettype none
module wcp_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire wcp_pkg::wcp_result_t push_rec,
  input  wire logic                 pop,
  output wcp_pkg::wcp_result_t      head_rec,
  output wcp_pkg::wcp_qstat_t       stat
);

  wcp_pkg::wcp_result_t mem_r [wcp_pkg::QUEUE_DEPTH];
  logic [wcp_pkg::QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [wcp_pkg::QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [wcp_pkg::QUEUE_AW:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + (wcp_pkg::QUEUE_AW)'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + (wcp_pkg::QUEUE_AW)'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (wcp_pkg::QUEUE_AW + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (wcp_pkg::QUEUE_AW + 1)'(1);
    end
  end

  assign head_rec   = mem_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.empty = count_r == '0;
  assign stat.full  = count_r == (wcp_pkg::QUEUE_AW + 1)'(wcp_pkg::QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/wcp_out.sv @@
// Output register stage: drains the queue onto the result stream.
`default_nettype none
module wcp_out (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire wcp_pkg::wcp_qstat_t   q_stat,
  input  wire wcp_pkg::wcp_result_t  head_rec,
  output logic                       pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [wcp_pkg::TDATA_W-1:0] out_tdata,
  output logic [1:0]                 out_tuser,
  output logic                       out_tlast
);

  logic                 valid_r, valid_nxt;
  wcp_pkg::wcp_result_t rec_r;

  assign pop = !q_stat.empty && (!valid_r || out_tready);

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec_r <= head_rec;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = rec_r.kind;
  assign out_tlast  = rec_r.frame_end;
  assign out_tdata  = {rec_r.form_type, rec_r.samp_bits, rec_r.frame_bytes,
                       rec_r.data_rate, rec_r.samp_rate, rec_r.chan_total,
                       rec_r.fmt_code, rec_r.channel, rec_r.sample_value};

endmodule
`default_nettype wire
